// ===== rtl/core/pcq_pkg.sv =====
package pcq_pkg;

  localparam int PinCount = 16;
  localparam int PinWidth = 16;
  localparam int IdxWidth = 4;
  localparam int CfgIdxWidth = 2;

  typedef enum logic [1:0] {
    KindPress   = 2'd0,
    KindRelease = 2'd1,
    KindRotary  = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegPressEnable   = 2'd0,
    RegReleaseEnable = 2'd1,
    RegRotaryEnable  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic press_en;
    logic release_en;
    logic rotary_en;
  } cfg_t;

  typedef struct packed {
    logic hit;
    logic rise;
  } lane_evt_t;

  typedef struct packed {
    logic              hit;
    logic signed [1:0] step;
  } quad_evt_t;

  typedef struct packed {
    logic [PinWidth-1:0] pend;
    logic [PinWidth-1:0] rel;
    logic                rot;
    logic signed [1:0]   step;
  } sample_evt_t;

  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] s;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/pcq_lane.sv =====
module pcq_lane (
  input  logic              level_now_i,
  input  logic              level_prev_i,
  input  pcq_pkg::cfg_t     cfg_i,
  output pcq_pkg::lane_evt_t evt_o
);

  logic changed;

  always_comb begin
    changed = level_now_i ^ level_prev_i;
    evt_o.rise = level_now_i;
    evt_o.hit = changed & (level_now_i ? cfg_i.release_en : cfg_i.press_en);
  end

endmodule

// ===== rtl/core/pcq_quad.sv =====
module pcq_quad (
  input  logic               pin_a_n_i,
  input  logic               pin_b_n_i,
  input  logic [1:0]         quad_prev_i,
  input  pcq_pkg::cfg_t      cfg_i,
  output logic [1:0]         quad_now_o,
  output pcq_pkg::quad_evt_t evt_o
);

  logic signed [1:0] step;

  always_comb begin
    quad_now_o = {~pin_a_n_i, ~pin_b_n_i};
    step = pcq_pkg::quad_step({quad_prev_i, quad_now_o});
    evt_o.step = step;
    evt_o.hit = (step != 2'sd0) & cfg_i.rotary_en;
  end

endmodule

// ===== rtl/core/pcq_merge.sv =====
module pcq_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  pcq_pkg::sample_evt_t  sample_i,
  output logic                  ready_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            event_kind_o,
  output logic [3:0]            pin_index_o,
  output logic signed [1:0]     rotary_step_o,
  output logic                  last_event_o
);

  logic [pcq_pkg::PinWidth-1:0] pend_q, rel_q;
  logic                         rot_q;
  logic signed [1:0]            step_q;

  logic                         out_valid_q;
  pcq_pkg::kind_e               out_kind_q;
  logic [3:0]                   out_pin_q;
  logic signed [1:0]            out_step_q;
  logic                         out_last_q;

  logic [pcq_pkg::PinWidth-1:0] onehot, pend_rest;
  logic [3:0]                   pin_sel;
  logic                         has_pin, busy, rot_rest, done_now, out_free, emit, rel_sel;

  always_comb begin
    onehot = pend_q & (~pend_q + 16'd1);
    pin_sel = '0;
    for (int i = 0; i < pcq_pkg::PinWidth; i++) begin
      if (onehot[i]) begin
        pin_sel = 4'(i);
      end
    end
    rel_sel = |(rel_q & onehot);
    has_pin = |pend_q;
    busy = has_pin | rot_q;
    pend_rest = pend_q & ~onehot;
    rot_rest = has_pin ? rot_q : 1'b0;
    done_now = (pend_rest == '0) && !rot_rest;
    out_free = !out_valid_q || !out_stall_i;
    emit = busy && out_free;
    ready_o = !busy || (emit && done_now);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      rot_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        pend_q <= sample_i.pend;
        rot_q <= sample_i.rot;
      end else if (emit) begin
        pend_q <= pend_rest;
        rot_q <= rot_rest;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rel_q <= sample_i.rel;
      step_q <= sample_i.step;
    end
    if (emit) begin
      out_last_q <= done_now;
      if (has_pin) begin
        out_kind_q <= rel_sel ? pcq_pkg::KindRelease : pcq_pkg::KindPress;
        out_pin_q <= pin_sel;
        out_step_q <= 2'sd0;
      end else begin
        out_kind_q <= pcq_pkg::KindRotary;
        out_pin_q <= '0;
        out_step_q <= step_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_kind_o = out_kind_q;
  assign pin_index_o = out_pin_q;
  assign rotary_step_o = out_step_q;
  assign last_event_o = out_last_q;

`ifndef ASSERT_OFF
  a_rot_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q == pcq_pkg::KindRotary |-> out_step_q != 2'sd0 && out_pin_q == '0)
    else $error("rotary event with bad fields");

  a_pin_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q != pcq_pkg::KindRotary |-> out_step_q == 2'sd0)
    else $error("pin event with nonzero step");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !busy || (emit && done_now))
    else $error("item loaded over pending events");

  a_keep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !done_now |=> busy)
    else $error("pending events lost");
`endif

endmodule

// ===== rtl/core/pin_change_events_and_quadrature_top.sv =====
// channel | handshake                 | payload
// in      | in_valid_i / in_stall_o   | pin_levels_i
// out     | out_valid_o / out_stall_i | event_kind_o, pin_index_o, rotary_step_o, last_event_o
// cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
// a sample's events leave the event queue in the merge stage one per cycle
// while out_stall_i does not hold them; the next sample is taken
// in the cycle the last event of the one before moves to the output register
// reset: previous levels all ones, previous quadrature zero, enables off
// out_stall_i holds the output register and, through the queue, in_stall_o
module pin_change_events_and_quadrature_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [pcq_pkg::PinWidth-1:0]   pin_levels_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     event_kind_o,
  output logic [3:0]                     pin_index_o,
  output logic signed [1:0]              rotary_step_o,
  output logic                           last_event_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pcq_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic                           cfg_data_i
);

  logic [pcq_pkg::PinWidth-1:0] prev_levels_q;
  logic [1:0]                   prev_quad_q;
  pcq_pkg::cfg_t                cfg_q;
  logic [1:0]                   quad_now;
  pcq_pkg::lane_evt_t           lane_evt [pcq_pkg::PinWidth];
  pcq_pkg::quad_evt_t           quad_evt;
  pcq_pkg::sample_evt_t         sample;
  logic                         merge_ready, in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o = !merge_ready;
  assign in_accept = in_valid_i && merge_ready;

  for (genvar g = 0; g < pcq_pkg::PinWidth; g++) begin : g_lane
    if (g < pcq_pkg::PinCount) begin : g_on
      pcq_lane u_lane (
        .level_now_i  (pin_levels_i[g]),
        .level_prev_i (prev_levels_q[g]),
        .cfg_i        (cfg_q),
        .evt_o        (lane_evt[g])
      );
    end else begin : g_off
      assign lane_evt[g] = '0;
    end
  end

  pcq_quad u_quad (
    .pin_a_n_i   (pin_levels_i[14]),
    .pin_b_n_i   (pin_levels_i[15]),
    .quad_prev_i (prev_quad_q),
    .cfg_i       (cfg_q),
    .quad_now_o  (quad_now),
    .evt_o       (quad_evt)
  );

  always_comb begin
    for (int i = 0; i < pcq_pkg::PinWidth; i++) begin
      sample.pend[i] = lane_evt[i].hit;
      sample.rel[i] = lane_evt[i].rise;
    end
    sample.rot = quad_evt.hit;
    sample.step = quad_evt.step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_levels_q <= '1;
      prev_quad_q <= '0;
      cfg_q <= '0;
    end else begin
      if (in_accept) begin
        prev_levels_q <= pin_levels_i;
        prev_quad_q <= quad_now;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          pcq_pkg::RegPressEnable:   cfg_q.press_en <= cfg_data_i;
          pcq_pkg::RegReleaseEnable: cfg_q.release_en <= cfg_data_i;
          pcq_pkg::RegRotaryEnable:  cfg_q.rotary_en <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  pcq_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (in_accept),
    .sample_i      (sample),
    .ready_o       (merge_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_kind_o  (event_kind_o),
    .pin_index_o   (pin_index_o),
    .rotary_step_o (rotary_step_o),
    .last_event_o  (last_event_o)
  );

endmodule

// ===== verif/pin_change_events_and_quadrature_top_tb.sv =====
`timescale 1ns / 100ps

module pin_change_events_and_quadrature_top_tb;

  localparam logic [pcq_pkg::CfgIdxWidth-1:0] RegSpare = 2'd3;
  localparam int DrainCycles = 20;
  localparam int HoldCycles = 300;
  localparam int Phases = 8;
  localparam int ItemsPerPhase = 20;
  localparam logic signed [1:0] StepByTransition [16] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0,
    2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1,
    2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

  typedef struct packed {
    logic [1:0]        kind;
    logic [3:0]        pin;
    logic signed [1:0] step;
    logic              last;
  } pin_event_t;

  class event_scoreboard;
    logic [pcq_pkg::PinWidth-1:0] prev_levels;
    logic [1:0]                   prev_quad;
    logic                         press_en;
    logic                         release_en;
    logic                         rotary_en;
    pin_event_t                   expected_q[$];
    int                           errors;

    function new();
      prev_levels = '1;
      prev_quad   = 2'b00;
      press_en    = 1'b0;
      release_en  = 1'b0;
      rotary_en   = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(logic [pcq_pkg::CfgIdxWidth-1:0] idx, logic data);
      case (idx)
        pcq_pkg::RegPressEnable:   press_en = data;
        pcq_pkg::RegReleaseEnable: release_en = data;
        pcq_pkg::RegRotaryEnable:  rotary_en = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_sample(logic [pcq_pkg::PinWidth-1:0] levels);
      pin_event_t                   batch[$];
      pin_event_t                   ev;
      logic [pcq_pkg::PinWidth-1:0] changed;
      logic                         a;
      logic                         b;
      logic signed [1:0]            st;
      changed = levels ^ prev_levels;
      for (int i = 0; i < pcq_pkg::PinCount; i++) begin
        if (changed[i]) begin
          ev = '{kind: pcq_pkg::KindPress, pin: 4'(i), step: 2'sd0, last: 1'b0};
          if (!levels[i] && press_en) begin
            batch.push_back(ev);
          end else if (levels[i] && release_en) begin
            ev.kind = pcq_pkg::KindRelease;
            batch.push_back(ev);
          end
        end
      end
      a  = ~levels[14];
      b  = ~levels[15];
      st = StepByTransition[{prev_quad, a, b}];
      if (st != 2'sd0 && rotary_en) begin
        ev = '{kind: pcq_pkg::KindRotary, pin: 4'd0, step: st, last: 1'b0};
        batch.push_back(ev);
      end
      prev_quad   = {a, b};
      prev_levels = levels;
      if (batch.size() > 0) begin
        batch[batch.size() - 1].last = 1'b1;
      end
      foreach (batch[k]) expected_q.push_back(batch[k]);
    endfunction

    function void check_event(logic [1:0] kind, logic [3:0] pin, logic signed [1:0] step,
                              logic last);
      pin_event_t exp_ev;
      if (expected_q.size() == 0) begin
        $error("unexpected event: kind %0d pin %0d step %0d last %0d", kind, pin, step, last);
        errors++;
        return;
      end
      exp_ev = expected_q.pop_front();
      if (kind !== exp_ev.kind) begin
        $error("event_kind: expected %0d, got %0d", exp_ev.kind, kind);
        errors++;
      end
      if (pin !== exp_ev.pin) begin
        $error("pin_index: expected %0d, got %0d", exp_ev.pin, pin);
        errors++;
      end
      if (step !== exp_ev.step) begin
        $error("rotary_step: expected %0d, got %0d", exp_ev.step, step);
        errors++;
      end
      if (last !== exp_ev.last) begin
        $error("last_event: expected %0d, got %0d", exp_ev.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic [pcq_pkg::PinWidth-1:0]    pin_levels_i = '1;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [1:0]                      event_kind_o;
  logic [3:0]                      pin_index_o;
  logic signed [1:0]               rotary_step_o;
  logic                            last_event_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [pcq_pkg::CfgIdxWidth-1:0] cfg_index_i = '0;
  logic                            cfg_data_i = 1'b0;

  event_scoreboard              sb = new();
  logic                         calm = 1'b0;
  logic                         hold_req = 1'b0;
  logic [pcq_pkg::PinWidth-1:0] last_pins = '1;

  pin_change_events_and_quadrature_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pin_levels_i  (pin_levels_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_kind_o  (event_kind_o),
    .pin_index_o   (pin_index_o),
    .rotary_step_o (rotary_step_o),
    .last_event_o  (last_event_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("pin_change_events_and_quadrature_top_tb NOT OK");
    $finish;
  end

  // event sink with random and long stalls
  initial begin
    int hold_count;
    hold_count = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        sb.check_event(event_kind_o, pin_index_o, rotary_step_o, last_event_o);
      end
      if (hold_req && hold_count == 0) begin
        hold_count = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_count > 0) begin
        hold_count--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 7);
      end
    end
  end

  task automatic write_reg(input logic [pcq_pkg::CfgIdxWidth-1:0] idx, input logic data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic set_enables(input logic press, input logic rel, input logic rot);
    write_reg(pcq_pkg::RegPressEnable, press);
    write_reg(pcq_pkg::RegReleaseEnable, rel);
    write_reg(pcq_pkg::RegRotaryEnable, rot);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_sample(input logic [pcq_pkg::PinWidth-1:0] levels);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pin_levels_i <= levels;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_sample(levels);
    last_pins = levels;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [pcq_pkg::PinWidth-1:0] next_levels(
    logic [pcq_pkg::PinWidth-1:0] prev);
    logic [pcq_pkg::PinWidth-1:0] v;
    case ($urandom_range(9))
      0, 1, 2: v = pcq_pkg::PinWidth'($urandom);
      3, 4, 5: begin
        v = prev ^ (16'h1 << $urandom_range(15));
        if ($urandom_range(1)) v ^= 16'h1 << $urandom_range(15);
      end
      default: begin
        // encoder walk on pins 14 and 15
        v = prev ^ (16'h1 << (14 + $urandom_range(1)));
        if ($urandom_range(1)) v ^= 16'h1 << $urandom_range(13);
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [pcq_pkg::PinWidth-1:0] batch[$];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(RegSpare, 1'b1);
    set_enables(1'b1, 1'b1, 1'b1);
    batch = '{16'hFFFF, 16'h0000, 16'hFFFF,
              16'hBFFF, 16'h3FFF, 16'h7FFF, 16'hFFFF,
              16'h7FFF, 16'h3FFF, 16'hBFFF, 16'hFFFF, 16'hFFFE};
    foreach (batch[k]) send_sample(batch[k]);
    drain();

    set_enables(1'b1, 1'b0, 1'b0);
    batch = '{16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF};
    foreach (batch[k]) send_sample(batch[k]);
    drain();

    set_enables(1'b0, 1'b1, 1'b1);
    batch = '{16'h7FFF, 16'h0000, 16'h8001};
    foreach (batch[k]) send_sample(batch[k]);
    drain();

    set_enables(1'b0, 1'b0, 1'b0);
    batch = '{16'h1234, 16'hFFFF};
    foreach (batch[k]) send_sample(batch[k]);
    drain();

    for (int p = 0; p < Phases; p++) begin
      if (p < 2) begin
        set_enables(1'b1, 1'b1, 1'b1);
      end else begin
        set_enables(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      calm = (p == 3);
      if (p == 1) hold_req = 1'b1;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (p == 4 && n == ItemsPerPhase / 2) begin
          // hold input until every pending event is out
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (sb.pending() != 0) @(posedge clk_i);
        end
        send_sample(next_levels(last_pins));
      end
      drain();
    end
    calm = 1'b0;

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("pin_change_events_and_quadrature_top_tb OK");
    end else begin
      $display("pin_change_events_and_quadrature_top_tb NOT OK");
    end
    $finish;
  end

endmodule
